// ===== rtl/rle8_pkg.sv =====
package rle8_pkg;

  localparam int COORD_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int COORD_W             = 16;
  localparam int ADDR_W              = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } rle8_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [7:0]         run_length;
    logic [7:0]         color_index;
    logic               end_of_image;
    logic               out_of_range;
  } rle8_out_t;

  // Run descriptor passed from the parser to the address stage.
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [7:0]         run_length;
    logic [7:0]         color_index;
    logic               end_of_image;
  } rle8_desc_t;

endpackage

// ===== rtl/rle8_bitmap_decoder.sv =====
// Channel   Direction  Handshake              Payload
// input     in         push / full            item   (data_byte, start_of_image)
// result    out        pop / empty            result (run descriptor)
// config    in         cfg_we                 cfg_data (image_width)
//
// One byte is taken per cycle while full is low; a byte gives at most one result.
// A result reaches the ports through the queue and then the two-stage address unit,
// whose first stage registers the product of a 16 by 16 multiplier.
// Reset clears the parser, the queue and the output stage, and sets the width to 1.
// A stalled result side fills the queue, and full then holds off further bytes.
module rle8_bitmap_decoder
  import rle8_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rle8_in_t           item,
  output logic               empty,
  input  logic               pop,
  output rle8_out_t          result,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_data
);

  logic       accept;
  logic       desc_push;
  rle8_desc_t front_desc;
  logic       q_valid;
  logic       q_pop;
  rle8_desc_t q_desc;

  assign accept = push && !full;

  rle8_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .desc_push(desc_push),
    .desc     (front_desc)
  );

  rle8_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (desc_push),
    .wr_data(front_desc),
    .full   (full),
    .rd     (q_pop),
    .valid  (q_valid),
    .rd_data(q_desc)
  );

  rle8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .desc_valid(q_valid),
    .desc      (q_desc),
    .desc_pop  (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== rtl/rle8_front.sv =====
module rle8_front
  import rle8_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  rle8_in_t   item,
  output logic       desc_push,
  output rle8_desc_t desc
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_SECOND,
    PH_DX,
    PH_DY,
    PH_LITERAL,
    PH_PAD,
    PH_DONE
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            held_count, held_count_next;
  logic [7:0]            literal_left, literal_left_next;
  logic                  pad_pending, pad_pending_next;
  logic [COORD_BITS-1:0] cur_column, cur_column_next;
  logic [COORD_BITS-1:0] cur_row, cur_row_next;

  phase_t                ph;
  logic [7:0]            hc;
  logic [7:0]            ll;
  logic                  pp;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] rw;
  logic [7:0]            b;
  logic [7:0]            ll_dec;

  // A start of image clears the whole parser state before the byte is parsed.
  always_comb begin
    if (item.start_of_image) begin
      ph  = PH_COUNT;
      hc  = '0;
      ll  = '0;
      pp  = 1'b0;
      col = '0;
      rw  = '0;
    end else begin
      ph  = phase;
      hc  = held_count;
      ll  = literal_left;
      pp  = pad_pending;
      col = cur_column;
      rw  = cur_row;
    end
  end

  assign b      = item.data_byte;
  assign ll_dec = ll - 8'd1;

  always_comb begin
    phase_next        = ph;
    held_count_next   = hc;
    literal_left_next = ll;
    pad_pending_next  = pp;
    cur_column_next   = col;
    cur_row_next      = rw;
    desc_push         = 1'b0;
    desc.column       = COORD_W'(col);
    desc.row          = COORD_W'(rw);
    desc.run_length   = 8'd1;
    desc.color_index  = b;
    desc.end_of_image = 1'b0;
    case (ph)
      PH_COUNT: begin
        held_count_next = b;
        phase_next      = PH_SECOND;
      end
      PH_SECOND: begin
        if (hc != 8'd0) begin
          desc_push       = accept;
          desc.run_length = hc;
          cur_column_next = col + COORD_BITS'(hc);
          phase_next      = PH_COUNT;
        end else if (b == 8'd0) begin
          cur_column_next = '0;
          cur_row_next    = rw + COORD_BITS'(1);
          phase_next      = PH_COUNT;
        end else if (b == 8'd1) begin
          desc_push         = accept;
          desc.run_length   = 8'd0;
          desc.color_index  = 8'd0;
          desc.end_of_image = 1'b1;
          phase_next        = PH_DONE;
        end else if (b == 8'd2) begin
          phase_next = PH_DX;
        end else begin
          literal_left_next = b;
          pad_pending_next  = b[0];
          phase_next        = PH_LITERAL;
        end
      end
      PH_DX: begin
        cur_column_next = col + COORD_BITS'(b);
        phase_next      = PH_DY;
      end
      PH_DY: begin
        cur_row_next = rw + COORD_BITS'(b);
        phase_next   = PH_COUNT;
      end
      PH_LITERAL: begin
        desc_push         = accept;
        cur_column_next   = col + COORD_BITS'(1);
        literal_left_next = ll_dec;
        if (ll_dec == 8'd0) begin
          phase_next = pp ? PH_PAD : PH_COUNT;
        end
      end
      PH_PAD: begin
        pad_pending_next = 1'b0;
        phase_next       = PH_COUNT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      held_count   <= '0;
      literal_left <= '0;
      pad_pending  <= 1'b0;
      cur_column   <= '0;
      cur_row      <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      held_count   <= held_count_next;
      literal_left <= literal_left_next;
      pad_pending  <= pad_pending_next;
      cur_column   <= cur_column_next;
      cur_row      <= cur_row_next;
    end
  end

endmodule

// ===== rtl/rle8_queue.sv =====
module rle8_queue
  import rle8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  rle8_desc_t wr_data,
  output logic       full,
  input  logic       rd,
  output logic       valid,
  output rle8_desc_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rle8_desc_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/rle8_back.sv =====
module rle8_back
  import rle8_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_data,
  input  logic               desc_valid,
  input  rle8_desc_t         desc,
  output logic               desc_pop,
  output logic               empty,
  input  logic               pop,
  output rle8_out_t          result
);

  logic [COORD_W-1:0] image_width;

  logic               s1_valid;
  rle8_desc_t         s1_desc;
  logic [ADDR_W-1:0]  s1_prod;
  logic [COORD_W:0]   s1_end;
  logic               s2_valid;
  logic               s1_ready;
  logic               s2_ready;
  logic [ADDR_W-1:0]  prod;

  assign s2_ready = !s2_valid || pop;
  assign s1_ready = !s1_valid || s2_ready;
  assign desc_pop = desc_valid && s1_ready;
  assign empty    = !s2_valid;
  assign prod     = ADDR_W'(desc.row) * ADDR_W'(image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= COORD_W'(1);
    end else if (cfg_we) begin
      image_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= desc_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      s1_desc <= desc;
      s1_prod <= prod;
      s1_end  <= (COORD_W + 1)'(desc.column) + (COORD_W + 1)'(desc.run_length);
    end
    if (s1_valid && s2_ready) begin
      result.pixel_address <= s1_prod + ADDR_W'(s1_desc.column);
      result.column        <= s1_desc.column;
      result.row           <= s1_desc.row;
      result.run_length    <= s1_desc.run_length;
      result.color_index   <= s1_desc.color_index;
      result.end_of_image  <= s1_desc.end_of_image;
      result.out_of_range  <= !s1_desc.end_of_image &&
                              (s1_end > (COORD_W + 1)'(image_width));
    end
  end

endmodule

// ===== dv/rle8_escape_pkg.sv =====
`timescale 1ns / 1ps

package rle8_escape_pkg;

  localparam logic [7:0] ESCAPE_INTRO  = 8'd0;
  localparam logic [7:0] ESC_END_LINE  = 8'd0;
  localparam logic [7:0] ESC_END_IMAGE = 8'd1;
  localparam logic [7:0] ESC_DELTA     = 8'd2;
  localparam logic [7:0] ABS_MIN_COUNT = 8'd3;

endpackage

// ===== dv/rle8_run_checker.sv =====
`timescale 1ns / 1ps

module rle8_run_checker
  import rle8_pkg::*;
  import rle8_escape_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  rle8_in_t           item,
  input  logic               empty,
  input  logic               pop,
  input  rle8_out_t          result,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 pending
);

  typedef enum logic [2:0] {
    SEEK_COUNT,
    SEEK_SECOND,
    SEEK_DX,
    SEEK_DY,
    SEEK_LITERAL,
    SEEK_PAD,
    STREAM_OVER
  } parse_phase_t;

  rle8_out_t          expected_runs[$];
  parse_phase_t       phase_q;
  logic [7:0]         held_count_q;
  logic [7:0]         literal_left_q;
  logic               pad_q;
  logic [COORD_W-1:0] col_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] width_q;

  task automatic clear_position();
    phase_q        = SEEK_COUNT;
    held_count_q   = '0;
    literal_left_q = '0;
    pad_q          = 1'b0;
    col_q          = '0;
    row_q          = '0;
  endtask

  function automatic rle8_out_t make_run(input logic [7:0] run, input logic [7:0] color,
                                         input logic eoi);
    rle8_out_t r;
    r.pixel_address = {16'b0, col_q} + {16'b0, row_q} * {16'b0, width_q};
    r.column        = col_q;
    r.row           = row_q;
    r.run_length    = run;
    r.color_index   = color;
    r.end_of_image  = eoi;
    r.out_of_range  = !eoi && (({1'b0, col_q} + 17'(run)) > {1'b0, width_q});
    return r;
  endfunction

  task automatic parse_byte(input rle8_in_t in_item);
    logic [7:0] b;
    b = in_item.data_byte;
    if (in_item.start_of_image) clear_position();
    case (phase_q)
      SEEK_COUNT: begin
        held_count_q = b;
        phase_q      = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        if (held_count_q != ESCAPE_INTRO) begin
          expected_runs.push_back(make_run(held_count_q, b, 1'b0));
          col_q   = col_q + COORD_W'(held_count_q);
          phase_q = SEEK_COUNT;
        end else if (b == ESC_END_LINE) begin
          col_q   = '0;
          row_q   = row_q + 1'b1;
          phase_q = SEEK_COUNT;
        end else if (b == ESC_END_IMAGE) begin
          expected_runs.push_back(make_run(8'd0, 8'd0, 1'b1));
          phase_q = STREAM_OVER;
        end else if (b == ESC_DELTA) begin
          phase_q = SEEK_DX;
        end else begin
          literal_left_q = b;
          pad_q          = b[0];
          phase_q        = SEEK_LITERAL;
        end
      end
      SEEK_DX: begin
        col_q   = col_q + COORD_W'(b);
        phase_q = SEEK_DY;
      end
      SEEK_DY: begin
        row_q   = row_q + COORD_W'(b);
        phase_q = SEEK_COUNT;
      end
      SEEK_LITERAL: begin
        expected_runs.push_back(make_run(8'd1, b, 1'b0));
        col_q          = col_q + 1'b1;
        literal_left_q = literal_left_q - 1'b1;
        if (literal_left_q == 8'd0) phase_q = pad_q ? SEEK_PAD : SEEK_COUNT;
      end
      SEEK_PAD: begin
        pad_q   = 1'b0;
        phase_q = SEEK_COUNT;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  // A result transfer is compared before the byte taken at the same edge is parsed.
  always @(posedge clk) begin
    rle8_out_t want;
    if (rst) begin
      expected_runs.delete();
      mismatches = 0;
      width_q = 16'd1;
      clear_position();
    end else begin
      if (pop && !empty) begin
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: address %0h column %0h row %0h run %0h index %0h",
                     result.pixel_address, result.column, result.row,
                     result.run_length, result.color_index);
        end else begin
          want = expected_runs.pop_front();
          check_field("pixel_address", want.pixel_address, result.pixel_address);
          check_field("column", 32'(want.column), 32'(result.column));
          check_field("row", 32'(want.row), 32'(result.row));
          check_field("run_length", 32'(want.run_length), 32'(result.run_length));
          check_field("color_index", 32'(want.color_index), 32'(result.color_index));
          check_field("end_of_image", 32'(want.end_of_image), 32'(result.end_of_image));
          check_field("out_of_range", 32'(want.out_of_range), 32'(result.out_of_range));
        end
      end
      if (cfg_we) width_q = cfg_data;
      if (push && !full) parse_byte(item);
    end
    pending = expected_runs.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import rle8_pkg::*;
  import rle8_escape_pkg::*;
();

  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SLOW,
    DRAIN_BURSTY
  } drain_mode_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               push     = 1'b0;
  rle8_in_t           item     = '0;
  logic               pop      = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic               full;
  logic               empty;
  rle8_out_t          result;
  int                 mismatches;
  int                 pending;

  int          burst_left = 0;
  int          sent_bytes = 0;
  bit          resync     = 1'b1;
  drain_mode_t drain_mode = DRAIN_FREE;
  int          mode_left  = 0;
  int          hold_left  = 0;

  rle8_bitmap_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rle8_run_checker run_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 120);
      end
      mode_left--;
      case (drain_mode)
        DRAIN_FREE: pop <= 1'b1;
        DRAIN_COIN: pop <= 1'($urandom_range(0, 1));
        DRAIN_SLOW: pop <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
          end else begin
            pop <= 1'b1;
            hold_left = $urandom_range(4, 30);
          end
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= '{data_byte: b, start_of_image: sof};
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic send_sequence(input bit far);
    int  pick;
    int  n;
    logic sof;
    sof    = resync || (!far && $urandom_range(0, 49) == 0);
    resync = 1'b0;
    pick   = $urandom_range(0, 99);
    if (far) begin
      send_byte(ESCAPE_INTRO, sof);
      send_byte(ESC_DELTA, 1'b0);
      send_byte(8'($urandom_range(250, 255)), 1'b0);
      send_byte(8'($urandom_range(250, 255)), 1'b0);
    end else if (pick < 40) begin
      send_byte(8'($urandom_range(1, 255)), sof);
      send_byte(8'($urandom), 1'b0);
    end else if (pick < 50) begin
      send_byte(ESCAPE_INTRO, sof);
      send_byte(ESC_END_LINE, 1'b0);
    end else if (pick < 60) begin
      send_byte(ESCAPE_INTRO, sof);
      send_byte(ESC_DELTA, 1'b0);
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
    end else if (pick < 84) begin
      n = (pick == 83) ? 255
                       : $urandom_range(ABS_MIN_COUNT, ($urandom_range(0, 3) == 0) ? 40 : 12);
      send_byte(ESCAPE_INTRO, sof);
      send_byte(8'(n), 1'b0);
      repeat (n) send_byte(8'($urandom), 1'b0);
      if (n % 2 == 1) send_byte(8'($urandom), 1'b0);
    end else if (pick < 88) begin
      send_byte(ESCAPE_INTRO, sof);
      send_byte(ESC_END_IMAGE, 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
      resync = 1'b1;
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
      resync = 1'b1;
    end
  endtask

  task automatic set_width(input logic [COORD_W-1:0] w);
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(negedge clk);
    cfg_we     <= 1'b0;
    burst_left = 0;
    resync     = 1'b1;
    sent_bytes = 0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // The width keeps its reset value of one for the directed part.
    send_byte(8'd255, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ESCAPE_INTRO, 1'b0);
    send_byte(ESC_END_LINE, 1'b0);
    send_byte(ESCAPE_INTRO, 1'b0);
    send_byte(ESC_DELTA, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(ESCAPE_INTRO, 1'b0);
    send_byte(ABS_MIN_COUNT, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(ESCAPE_INTRO, 1'b0);
    send_byte(ESC_END_IMAGE, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h40, 1'b1);
    send_byte(8'd7, 1'b1);
    send_byte(8'd9, 1'b0);

    set_width(16'd640);
    while (sent_bytes < 120) send_sequence(1'b0);

    set_width(16'd0);
    while (sent_bytes < 100) send_sequence(1'b0);

    // Long deltas at full width carry both coordinates round past their wrap.
    set_width(16'hFFFF);
    for (int i = 0; i < 300; i++) begin
      if (i % 12 == 11) begin
        send_byte(8'($urandom_range(1, 255)), 1'b0);
        send_byte(8'($urandom), 1'b0);
      end else begin
        send_sequence(1'b1);
      end
    end

    set_width(16'($urandom_range(1, 65535)));
    while (sent_bytes < 120) send_sequence(1'b0);

    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
